// ===== src/fets_pkg.sv =====
`timescale 1ns / 1ps

package fets_pkg;

    // field widths
    localparam int unsigned TimeW    = 32;
    localparam int unsigned SensW    = 24;
    localparam int unsigned CfgW     = 38;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned MaskW    = 8;
    localparam int unsigned PortW    = 8;
    localparam int unsigned ActW     = 3;
    localparam int unsigned TrigIdxW = 3;

    // default sizes
    localparam int unsigned DefTriggerCount = 8;
    localparam int unsigned DefPyroPorts    = 4;

    // thresholds
    localparam logic signed [SensW-1:0] SepVelLimit     = 24'sd1830;
    localparam logic signed [SensW-1:0] SepAccLimit     = 24'sd1000;
    localparam logic [TimeW-1:0]        TouchdownWaitMs = 32'd60000;
    localparam logic [TimeW-1:0]        SepDelayMs      = 32'd1500;

    typedef enum logic [1:0] {
        MODE_UPDATE    = 2'd0,
        MODE_APOGEE    = 2'd1,
        MODE_TOUCHDOWN = 2'd2,
        MODE_RESTORE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        EV_NEVER      = 3'd0,
        EV_LAUNCH     = 3'd1,
        EV_APOGEE     = 3'd2,
        EV_APOGEE_DLY = 3'd3,
        EV_ALTITUDE   = 3'd4,
        EV_TOUCHDOWN  = 3'd5,
        EV_SEP        = 3'd6,
        EV_SEP_DLY    = 3'd7
    } t_event;

    typedef enum logic [ActW-1:0] {
        ACT_PYRO     = 3'd0,
        ACT_OUT_ON   = 3'd1,
        ACT_OUT_OFF  = 3'd2,
        ACT_PWM      = 3'd3,
        ACT_LINE_CUT = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LAST = 3'b100
    } t_state;

    typedef struct packed {
        logic [TrigIdxW-1:0] idx;
        logic [ActW-1:0]     action;
        logic [PortW-1:0]    port;
        logic [MaskW-1:0]    mask;
    } t_result;

endpackage

// ===== src/flight_event_trigger_sequencer.sv =====
`timescale 1ns / 1ps

// Deployment trigger sequencer. A mode 1, 2 or 3 word (apogee time, touchdown
// time, fired mask restore) is absorbed on the accept edge and gives no output. An
// update word latches the separation event on the accept edge, then checks one
// trigger per cycle, unless the output side stalls, through a single shared
// elapsed-time subtract and compare unit; the input side stays busy until the
// scan and the final held fire are done. Each fire yields one output word;
// the last fire of an update carries o_last. Fires are held one word back so
// that o_last is known; an output register decouples the consumer.
module flight_event_trigger_sequencer
    import fets_pkg::*;
#(
    parameter int unsigned TRIGGER_COUNT = DefTriggerCount,
    parameter int unsigned PYRO_PORTS    = DefPyroPorts
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CfgIdxW-1:0]      i_cfg_idx,
    input  logic [CfgW-1:0]         i_cfg_data,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_mode,
    input  logic [TimeW-1:0]        i_time_ms,
    input  logic                    i_launched,
    input  logic                    i_past_apogee,
    input  logic                    i_landed,
    input  logic signed [SensW-1:0] i_vel_z_cms,
    input  logic signed [SensW-1:0] i_acc_z_cms2,
    input  logic signed [SensW-1:0] i_altitude_dm,
    input  logic [MaskW-1:0]        i_restore_mask,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [TrigIdxW-1:0]     o_trigger_index,
    output logic [ActW-1:0]         o_action,
    output logic [PortW-1:0]        o_port,
    output logic [MaskW-1:0]        o_fired_mask,
    output logic                    o_last
);

    localparam int unsigned IdxW = (TRIGGER_COUNT > 1) ? $clog2(TRIGGER_COUNT) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TRIGGER_COUNT - 1);

    // state
    t_state                   r_state, n_state;
    logic [IdxW-1:0]          r_idx;
    logic [CfgW-1:0]          r_trig [TRIGGER_COUNT];
    logic [TRIGGER_COUNT-1:0] r_fired;
    logic [TimeW-1:0]         r_apo_time, r_td_time, r_sep_time;
    logic                     r_sep_seen;
    // latched update word
    logic [TimeW-1:0]         r_now;
    logic                     r_launched, r_apogee, r_landed;
    logic signed [SensW-1:0]  r_alt;
    // held-back fire and output register
    logic                     r_pend_valid;
    t_result                  r_pend;
    logic                     r_out_valid;
    t_result                  r_out;
    logic                     r_out_last;

    logic accept;
    logic out_free;
    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // current trigger fields
    logic [CfgW-1:0]   word;
    logic [2:0]        ev_code;
    logic [ActW-1:0]   act;
    logic [PortW-1:0]  port;
    logic [SensW-1:0]  val;
    assign word    = r_trig[r_idx];
    assign ev_code = word[2:0];
    assign act     = word[5:3];
    assign port    = word[13:6];
    assign val     = word[37:14];

    // shared elapsed-time unit: base and limit chosen by event
    logic [TimeW-1:0] delay_ms;
    logic [TimeW-1:0] base_time, limit_ms, elapsed;
    logic             elapsed_over;
    assign delay_ms = {2'b00, val, 6'b0} + {3'b000, val, 5'b0} + {6'b0, val, 2'b0};

    always_comb begin
        case (t_event'(ev_code))
            EV_APOGEE_DLY: begin
                base_time = r_apo_time;
                limit_ms  = delay_ms;
            end
            EV_TOUCHDOWN: begin
                base_time = r_td_time;
                limit_ms  = TouchdownWaitMs;
            end
            default: begin
                base_time = r_sep_time;
                limit_ms  = SepDelayMs;
            end
        endcase
    end
    assign elapsed      = r_now - base_time;
    assign elapsed_over = elapsed > limit_ms;

    // altitude below value, signed against unsigned
    logic alt_below;
    assign alt_below = $signed({r_alt[SensW-1], r_alt}) < $signed({1'b0, val});

    // event check
    logic hit;
    always_comb begin
        case (t_event'(ev_code))
            EV_NEVER:      hit = 1'b0;
            EV_LAUNCH:     hit = r_launched;
            EV_APOGEE:     hit = r_apogee;
            EV_APOGEE_DLY: hit = r_apogee && elapsed_over;
            EV_ALTITUDE:   hit = r_apogee && alt_below;
            EV_TOUCHDOWN:  hit = r_landed && elapsed_over;
            EV_SEP:        hit = r_sep_seen;
            EV_SEP_DLY:    hit = r_sep_seen && elapsed_over;
            default:       hit = 1'b0;
        endcase
    end

    // action and port gating
    logic act_ok, fire, stall;
    always_comb begin
        case (t_action'(act))
            ACT_LINE_CUT:                         act_ok = 1'b1;
            ACT_PYRO, ACT_OUT_ON, ACT_OUT_OFF,
            ACT_PWM:                              act_ok = port < PortW'(PYRO_PORTS);
            default:                              act_ok = 1'b0;
        endcase
    end
    assign fire  = (r_state == S_SCAN) && !r_fired[r_idx] && hit && act_ok;
    assign stall = fire && r_pend_valid && !out_free;

    logic [TRIGGER_COUNT-1:0] fired_after;
    always_comb begin
        fired_after = r_fired;
        fired_after[r_idx] = 1'b1;
    end

    // separation latch condition
    logic sep_now;
    assign sep_now = !r_sep_seen && i_launched && (i_vel_z_cms < SepVelLimit)
                     && (i_acc_z_cms2 < SepAccLimit);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept && t_mode'(i_mode) == MODE_UPDATE) n_state = S_SCAN;
            S_SCAN: if (!stall && r_idx == LastIdx) n_state = S_LAST;
            S_LAST: if (!r_pend_valid || out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (accept) begin
            r_idx <= '0;
        end else if (r_state == S_SCAN && !stall && r_idx != LastIdx) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // trigger configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TRIGGER_COUNT; k++) r_trig[k] <= '0;
        end else if (i_cfg_we && ({1'b0, i_cfg_idx} < (CfgIdxW + 1)'(TRIGGER_COUNT))) begin
            r_trig[i_cfg_idx[IdxW-1:0]] <= i_cfg_data;
        end
    end

    // timestamps, separation latch, fired mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apo_time <= '0;
            r_td_time  <= '0;
            r_sep_time <= '0;
            r_sep_seen <= 1'b0;
            r_fired    <= '0;
        end else if (accept) begin
            case (t_mode'(i_mode))
                MODE_APOGEE:    r_apo_time <= i_time_ms;
                MODE_TOUCHDOWN: r_td_time  <= i_time_ms;
                MODE_RESTORE:   r_fired    <= i_restore_mask[TRIGGER_COUNT-1:0];
                MODE_UPDATE: begin
                    if (sep_now) begin
                        r_sep_seen <= 1'b1;
                        r_sep_time <= i_time_ms;
                    end
                end
                default: ;
            endcase
        end else if (fire && !stall) begin
            r_fired <= fired_after;
        end
    end

    // latched update word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now      <= i_time_ms;
            r_launched <= i_launched;
            r_apogee   <= i_past_apogee;
            r_landed   <= i_landed;
            r_alt      <= i_altitude_dm;
        end
    end

    // held-back fire and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire && !stall) begin
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                    r_out       <= r_pend;
                    r_out_last  <= 1'b0;
                end else if (r_out_valid && i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
                r_pend_valid <= 1'b1;
                r_pend.idx    <= TrigIdxW'(r_idx);
                r_pend.action <= act;
                r_pend.port   <= port;
                r_pend.mask   <= MaskW'(fired_after);
            end else if (r_state == S_LAST && r_pend_valid && out_free) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_pend;
                r_out_last   <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_trigger_index = r_out.idx;
    assign o_action        = r_out.action;
    assign o_port          = r_out.port;
    assign o_fired_mask    = r_out.mask;
    assign o_last          = r_out_last;

    // checks
    a_pend_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_state != S_IDLE)
        else $error("held fire while idle");

    a_mask_has_own_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fired_mask[o_trigger_index])
        else $error("output mask misses the firing trigger");

    a_non_update_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_mode'(i_mode) != MODE_UPDATE) |=> r_state == S_IDLE)
        else $error("non-update word started a scan");

    a_sep_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sep_seen |=> r_sep_seen)
        else $error("separation latch cleared");

endmodule

// ===== test/tb_flight_event_trigger_sequencer.sv =====
`timescale 1ns / 1ps

module tb_flight_event_trigger_sequencer;
    import fets_pkg::*;

    localparam int unsigned NumTriggers = DefTriggerCount;
    localparam int unsigned NumPyro     = DefPyroPorts;
    localparam int unsigned QuietCycles = 2 * (NumTriggers + 1) + 16;
    localparam int unsigned LongHold    = 300;
    localparam int unsigned StallLimit  = 5000;
    localparam int unsigned MaxReports  = 10;

    // action codes the block must refuse
    localparam logic [ActW-1:0] ActInvalidFirst = 3'd5;
    localparam logic [ActW-1:0] ActInvalidLast  = 3'd7;

    localparam logic [SensW-1:0] SensMax = 24'h7FFFFF;
    localparam logic [SensW-1:0] SensMin = 24'h800000;
    localparam logic [TimeW-1:0] TdBase  = 32'hFFFF_FF00;

    // kinds of trigger setup per phase
    typedef enum int {
        SETUP_ONES,
        SETUP_ZEROS,
        SETUP_RANDOM,
        SETUP_STORM
    } t_setup;

    typedef struct {
        t_mode                   mode;
        logic [TimeW-1:0]        time_ms;
        logic                    launched, past_apogee, landed;
        logic signed [SensW-1:0] vel, acc, alt;
        logic [MaskW-1:0]        restore_mask;
    } t_flight_word;

    typedef struct {
        logic [TrigIdxW-1:0] idx;
        logic [ActW-1:0]     action;
        logic [PortW-1:0]    port;
        logic [MaskW-1:0]    mask;
        logic                last;
    } t_fire;

    // trigger state tracker and fire queue
    class fire_scoreboard;
        logic [CfgW-1:0]  trig_cfg [NumTriggers];
        bit               fired [NumTriggers];
        logic [TimeW-1:0] apogee_ms, touchdown_ms, sep_ms;
        bit               sep_latched;
        t_fire            fire_q [$];
        int unsigned      mismatches, fires_checked, words_noted;

        function new();
            foreach (trig_cfg[i]) begin
                trig_cfg[i] = '0;
                fired[i]    = 1'b0;
            end
            apogee_ms     = '0;
            touchdown_ms  = '0;
            sep_ms        = '0;
            sep_latched   = 1'b0;
            mismatches    = 0;
            fires_checked = 0;
            words_noted   = 0;
        endfunction

        function void write_cfg(int unsigned idx, logic [CfgW-1:0] data);
            trig_cfg[idx] = data;
        endfunction

        function logic [MaskW-1:0] fired_mask();
            logic [MaskW-1:0] m;
            m = '0;
            for (int i = 0; i < NumTriggers; i++) m[i] = fired[i];
            return m;
        endfunction

        // accepted input word: update state and queue the fires it causes
        function void note_word(t_flight_word w);
            logic [2:0]       ev;
            logic [ActW-1:0]  act;
            logic [PortW-1:0] port;
            logic [23:0]      thr;
            logic [TimeW-1:0] elapsed;
            bit               hit;
            int               n;
            t_fire            f;
            words_noted++;
            case (w.mode)
                MODE_APOGEE: apogee_ms = w.time_ms;
                MODE_TOUCHDOWN: touchdown_ms = w.time_ms;
                MODE_RESTORE: begin
                    for (int i = 0; i < NumTriggers; i++) fired[i] = w.restore_mask[i];
                end
                default: begin
                    if (!sep_latched && w.launched && w.vel < SepVelLimit
                            && w.acc < SepAccLimit) begin
                        sep_latched = 1'b1;
                        sep_ms      = w.time_ms;
                    end
                    n = 0;
                    for (int i = 0; i < NumTriggers; i++) begin
                        ev   = trig_cfg[i][2:0];
                        act  = trig_cfg[i][5:3];
                        port = trig_cfg[i][13:6];
                        thr  = trig_cfg[i][37:14];
                        hit  = 1'b0;
                        case (t_event'(ev))
                            EV_LAUNCH: hit = w.launched;
                            EV_APOGEE: hit = w.past_apogee;
                            EV_APOGEE_DLY: begin
                                elapsed = w.time_ms - apogee_ms;
                                hit = w.past_apogee && (64'(elapsed) > 64'(thr) * 64'd100);
                            end
                            EV_ALTITUDE: hit = w.past_apogee && (longint'(w.alt) < longint'(thr));
                            EV_TOUCHDOWN: begin
                                elapsed = w.time_ms - touchdown_ms;
                                hit = w.landed && elapsed > TouchdownWaitMs;
                            end
                            EV_SEP: hit = sep_latched;
                            EV_SEP_DLY: begin
                                elapsed = w.time_ms - sep_ms;
                                hit = sep_latched && elapsed > SepDelayMs;
                            end
                            default: hit = 1'b0;
                        endcase
                        if (fired[i] || !hit || act > ACT_LINE_CUT) continue;
                        if (act != ACT_LINE_CUT && port >= NumPyro) continue;
                        fired[i] = 1'b1;
                        f.idx    = TrigIdxW'(i);
                        f.action = act;
                        f.port   = port;
                        f.mask   = fired_mask();
                        f.last   = 1'b0;
                        fire_q.push_back(f);
                        n++;
                    end
                    if (n > 0) fire_q[fire_q.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        // accepted output word: compare against oldest queued fire
        function void check_fire(t_fire got);
            t_fire want;
            fires_checked++;
            if (fire_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("unexpected fire: trig %0d act %0d port %0d mask %02h last %0d",
                             got.idx, got.action, got.port, got.mask, got.last);
                return;
            end
            want = fire_q.pop_front();
            if (got.idx !== want.idx || got.action !== want.action || got.port !== want.port
                    || got.mask !== want.mask || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MaxReports) begin
                    $display("fire mismatch: want trig %0d act %0d port %0d mask %02h last %0d",
                             want.idx, want.action, want.port, want.mask, want.last);
                    $display("               got  trig %0d act %0d port %0d mask %02h last %0d",
                             got.idx, got.action, got.port, got.mask, got.last);
                end
            end
        endfunction
    endclass

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [CfgIdxW-1:0]      i_cfg_idx      = '0;
    logic [CfgW-1:0]         i_cfg_data     = '0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_mode         = '0;
    logic [TimeW-1:0]        i_time_ms      = '0;
    logic                    i_launched     = 1'b0;
    logic                    i_past_apogee  = 1'b0;
    logic                    i_landed       = 1'b0;
    logic signed [SensW-1:0] i_vel_z_cms    = '0;
    logic signed [SensW-1:0] i_acc_z_cms2   = '0;
    logic signed [SensW-1:0] i_altitude_dm  = '0;
    logic [MaskW-1:0]        i_restore_mask = '0;
    logic                    o_out_valid;
    logic                    i_out_ready    = 1'b0;
    logic [TrigIdxW-1:0]     o_trigger_index;
    logic [ActW-1:0]         o_action;
    logic [PortW-1:0]        o_port;
    logic [MaskW-1:0]        o_fired_mask;
    logic                    o_last;

    fire_scoreboard   sb;
    logic [CfgW-1:0]  plan [NumTriggers];
    logic [TimeW-1:0] flight_clock  = 32'd10000;
    bit               calm          = 1'b0;
    bit               long_hold_req = 1'b0;
    int unsigned      setups        = 0;
    int unsigned      stall_cycles  = 0;

    flight_event_trigger_sequencer uut (.*);

    always #2 i_clk = ~i_clk;

    function automatic logic [CfgW-1:0] trig(t_event ev, logic [ActW-1:0] act,
                                             logic [PortW-1:0] port, logic [23:0] val);
        return {val, port, act, ev};
    endfunction

    function automatic t_flight_word update_word(logic [TimeW-1:0] t, logic la, logic ap,
                                                 logic ld, logic [SensW-1:0] v,
                                                 logic [SensW-1:0] a, logic [SensW-1:0] h);
        t_flight_word w;
        w.mode         = MODE_UPDATE;
        w.time_ms      = t;
        w.launched     = la;
        w.past_apogee  = ap;
        w.landed       = ld;
        w.vel          = v;
        w.acc          = a;
        w.alt          = h;
        w.restore_mask = '0;
        return w;
    endfunction

    function automatic t_flight_word mode_word(t_mode m, logic [TimeW-1:0] t,
                                               logic [MaskW-1:0] mask);
        t_flight_word w;
        w              = update_word(t, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        w.mode         = m;
        w.restore_mask = mask;
        return w;
    endfunction

    function automatic logic [CfgW-1:0] random_trigger(bit storm);
        t_event           ev;
        logic [ActW-1:0]  act;
        logic [PortW-1:0] port;
        logic [23:0]      val;
        int unsigned      r;
        r = $urandom_range(0, 9);
        if (r < 6) val = 24'($urandom_range(0, 300));
        else if (r < 8) val = 24'($urandom_range(0, 2000));
        else if (r < 9) val = 24'($urandom);
        else val = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h0;
        if (storm) begin
            case ($urandom_range(0, 2))
                0: ev = EV_LAUNCH;
                1: ev = EV_APOGEE;
                default: ev = EV_SEP;
            endcase
            return trig(ev, ACT_LINE_CUT, PortW'($urandom), val);
        end
        ev  = t_event'($urandom_range(EV_NEVER, EV_SEP_DLY));
        r   = $urandom_range(0, 9);
        act = (r < 8) ? ActW'($urandom_range(ACT_PYRO, ACT_LINE_CUT))
                      : ActW'($urandom_range(ActInvalidFirst, ActInvalidLast));
        r   = $urandom_range(0, 9);
        if (r < 8) port = PortW'($urandom_range(0, NumPyro - 1));
        else if (r < 9) port = PortW'($urandom_range(NumPyro, 255));
        else port = 8'hFF;
        return trig(ev, act, port, val);
    endfunction

    // random word, mostly plausible flight data near the decision points
    function automatic t_flight_word random_word();
        t_flight_word     w;
        int unsigned      r;
        logic [TimeW-1:0] anchor;
        logic [TimeW-1:0] delta;
        logic [23:0]      thr;
        w.time_ms      = $urandom;
        w.launched     = $urandom_range(0, 9) < 7;
        w.past_apogee  = $urandom_range(0, 9) < 7;
        w.landed       = $urandom_range(0, 9) < 7;
        w.restore_mask = ($urandom_range(0, 9) < 6) ? '0 : MaskW'($urandom);
        thr            = sb.trig_cfg[$urandom_range(0, NumTriggers - 1)][37:14];
        r              = $urandom_range(0, 99);
        if (r < 60) w.mode = MODE_UPDATE;
        else if (r < 72) w.mode = MODE_RESTORE;
        else if (r < 86) w.mode = MODE_APOGEE;
        else w.mode = MODE_TOUCHDOWN;

        // sensor values: near the separation limits or a trigger threshold, small, or anything
        r = $urandom_range(0, 9);
        if (r < 4) w.vel = SepVelLimit + SensW'($urandom_range(0, 4)) - SensW'(2);
        else if (r < 8) w.vel = SensW'($urandom_range(0, 10000)) - SensW'(5000);
        else w.vel = SensW'($urandom);
        r = $urandom_range(0, 9);
        if (r < 4) w.acc = SepAccLimit + SensW'($urandom_range(0, 4)) - SensW'(2);
        else if (r < 8) w.acc = SensW'($urandom_range(0, 10000)) - SensW'(5000);
        else w.acc = SensW'($urandom);
        r = $urandom_range(0, 9);
        if (r < 4) w.alt = thr + SensW'($urandom_range(0, 2)) - SensW'(1);
        else if (r < 7) w.alt = SensW'($urandom_range(0, 2100)) - SensW'(100);
        else w.alt = SensW'($urandom);

        if (w.mode == MODE_APOGEE || w.mode == MODE_TOUCHDOWN) begin
            if ($urandom_range(0, 9) < 8) w.time_ms = flight_clock - $urandom_range(0, 70000);
        end else if (w.mode == MODE_UPDATE && $urandom_range(0, 9) != 0) begin
            r = $urandom_range(0, 9);
            if (r < 3) anchor = sb.apogee_ms;
            else if (r < 5) anchor = sb.touchdown_ms;
            else if (r < 7) anchor = sb.sep_ms;
            else anchor = flight_clock;
            r = $urandom_range(0, 9);
            if (r < 3) delta = 32'(thr) * 32'd100;
            else if (r < 4) delta = TouchdownWaitMs;
            else if (r < 5) delta = SepDelayMs;
            else if (r < 8) delta = $urandom_range(0, 100000);
            else if (r < 9) delta = '0;
            else delta = $urandom;
            w.time_ms = anchor + delta + $urandom_range(0, 2) - 32'd1;
        end
        flight_clock += $urandom_range(0, 3000);
        return w;
    endfunction

    // write all trigger registers from plan, block must be idle
    task automatic load_plan();
        for (int i = 0; i < NumTriggers; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CfgIdxW'(i);
            i_cfg_data <= plan[i];
            sb.write_cfg(i, plan[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        setups++;
    endtask

    // offer one word and hold it until accepted, then maybe idle
    task automatic send_word(input t_flight_word w);
        int unsigned gap;
        i_in_valid     <= 1'b1;
        i_mode         <= w.mode;
        i_time_ms      <= w.time_ms;
        i_launched     <= w.launched;
        i_past_apogee  <= w.past_apogee;
        i_landed       <= w.landed;
        i_vel_z_cms    <= w.vel;
        i_acc_z_cms2   <= w.acc;
        i_altitude_dm  <= w.alt;
        i_restore_mask <= w.restore_mask;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering, wait for all fires, then let the scan finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.fire_q.size() != 0) @(posedge i_clk);
        repeat (QuietCycles) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_setup kind, input int unsigned n_items,
                             input bit pause_mid);
        for (int i = 0; i < NumTriggers; i++) begin
            case (kind)
                SETUP_ONES: plan[i] = '1;
                SETUP_ZEROS: plan[i] = '0;
                SETUP_STORM: plan[i] = random_trigger(1'b1);
                default: plan[i] = random_trigger(1'b0);
            endcase
        end
        load_plan();
        if (kind == SETUP_STORM) long_hold_req = 1'b1;
        for (int n = 0; n < n_items; n++) begin
            if (pause_mid && n == n_items / 2) wait_idle();
            send_word(random_word());
        end
        wait_idle();
    endtask

    // output side: check every accepted word
    always @(posedge i_clk) begin : fire_sink
        t_fire got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.idx    = o_trigger_index;
            got.action = o_action;
            got.port   = o_port;
            got.mask   = o_fired_mask;
            got.last   = o_last;
            sb.check_fire(got);
        end
    end

    // output side: ready with random stall bursts and one long hold-off
    initial begin : sink_ready
        int unsigned hold_left;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LongHold - 1;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 15);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
            $display("watchdog: no word accepted for %0d cycles", StallLimit);
            $display("tb_flight_event_trigger_sequencer: FAIL");
            $finish;
        end
    end

    initial begin : main_seq
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one trigger per event kind other than never, one refused action
        plan[0] = trig(EV_LAUNCH, ACT_PYRO, 8'd0, 24'd0);
        plan[1] = trig(EV_APOGEE, ACT_OUT_ON, PortW'(NumPyro - 1), 24'd0);
        plan[2] = trig(EV_APOGEE_DLY, ACT_PWM, 8'd1, 24'd20);
        plan[3] = trig(EV_ALTITUDE, ACT_LINE_CUT, 8'hFF, 24'd500);
        plan[4] = trig(EV_TOUCHDOWN, ACT_OUT_OFF, 8'd2, 24'd0);
        plan[5] = trig(EV_SEP, ACT_OUT_ON, 8'd0, 24'd0);
        plan[6] = trig(EV_LAUNCH, ActInvalidLast, 8'd0, 24'd0);
        plan[7] = trig(EV_SEP_DLY, ACT_LINE_CUT, 8'd200, 24'hFFFFFF);
        load_plan();
        send_word(update_word(32'd0, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        send_word(update_word(32'd100, 1'b1, 1'b0, 1'b0, 24'sd5000, 24'sd5000, '0));
        // velocity exactly at the limit does not separate
        send_word(update_word(32'd200, 1'b1, 1'b0, 1'b0, SepVelLimit, '0, '0));
        send_word(update_word(32'd1000, 1'b1, 1'b0, 1'b0, SepVelLimit - 24'sd1,
                              SepAccLimit - 24'sd1, '0));
        // separation latch holds, delay not yet exceeded
        send_word(update_word(32'd2500, 1'b1, 1'b0, 1'b0, SensMin, SensMax, SensMax));
        send_word(mode_word(MODE_APOGEE, 32'd3000, '0));
        // time before apogee stamp wraps to a huge elapsed time
        send_word(update_word(32'd2501, 1'b1, 1'b1, 1'b0, '0, '0, 24'sd500));
        send_word(mode_word(MODE_RESTORE, '0, 8'hFB));
        send_word(update_word(32'd5000, 1'b1, 1'b1, 1'b0, '0, '0, -24'sd1));
        send_word(update_word(32'd5001, 1'b1, 1'b1, 1'b0, '0, '0, -24'sd1));
        // altitude compare is strict
        send_word(mode_word(MODE_RESTORE, '0, 8'hF7));
        send_word(update_word(32'd6000, 1'b1, 1'b1, 1'b0, '0, '0, 24'sd500));
        send_word(update_word(32'd6000, 1'b1, 1'b1, 1'b0, '0, '0, 24'sd499));
        // touchdown wait across the 32-bit wrap
        send_word(mode_word(MODE_TOUCHDOWN, TdBase, '0));
        send_word(mode_word(MODE_RESTORE, '0, 8'hEF));
        send_word(update_word(TdBase + TouchdownWaitMs, 1'b1, 1'b1, 1'b1, '0, '0, '0));
        send_word(update_word(TdBase + TouchdownWaitMs + 32'd1, 1'b1, 1'b1, 1'b1,
                              '0, '0, '0));
        wait_idle();

        // pyro port out of range, then everything at once
        plan[4] = trig(EV_NEVER, ACT_PYRO, 8'd0, 24'd0);
        plan[6] = trig(EV_LAUNCH, ACT_PWM, PortW'(NumPyro), 24'd0);
        load_plan();
        send_word(mode_word(MODE_RESTORE, '0, 8'h00));
        send_word(update_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, SensMax, SensMax, SensMin));
        send_word(mode_word(MODE_RESTORE, '0, 8'hA5));
        send_word(update_word(32'h8000_0000, 1'b1, 1'b1, 1'b1, SensMin, SensMin, SensMin));
        wait_idle();

        // random phases, extremes included, quiet handshakes at the end
        run_phase(SETUP_ONES, 10, 1'b0);
        run_phase(SETUP_RANDOM, 40, 1'b1);
        run_phase(SETUP_STORM, 40, 1'b0);
        run_phase(SETUP_ZEROS, 10, 1'b0);
        run_phase(SETUP_RANDOM, 40, 1'b0);
        run_phase(SETUP_RANDOM, 40, 1'b0);
        calm = 1'b1;
        run_phase(SETUP_RANDOM, 30, 1'b0);

        $display("run covered %0d input words over %0d trigger setups",
                 sb.words_noted, setups);
        $display("%0d fires checked, %0d mismatches, %0d fires never seen",
                 sb.fires_checked, sb.mismatches, sb.fire_q.size());
        if (sb.mismatches == 0 && sb.fire_q.size() == 0) begin
            $display("tb_flight_event_trigger_sequencer: PASS");
        end else begin
            $display("tb_flight_event_trigger_sequencer: FAIL");
        end
        $finish;
    end

endmodule
